@@ rtl/dlsh_pkg.sv @@
// Package for the dual-lane sponge hash: payload types, sizes, round constants
// and the block padding helper. No dependencies.
package dlsh_pkg;

  localparam int unsigned RoundCount    = 12;
  localparam int unsigned DigestMaxBits = 4096;
  localparam int unsigned RateWords     = 6;
  localparam int unsigned CapWords      = 9;
  localparam int unsigned PermWords     = RateWords + CapWords;
  localparam int unsigned LaneBRcOffset = 12;
  localparam int unsigned Rot1          = 21;
  localparam int unsigned Rot2          = 43;
  localparam logic [63:0] TopBit        = 64'h8000000000000000;

  typedef struct packed {
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic [63:0] word4;
    logic [63:0] word5;
    logic [8:0]  valid_bits;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        last_word;
  } out_item_t;

  typedef logic [RateWords-1:0][63:0] rate_t;
  typedef logic [CapWords-1:0][63:0]  cap_t;
  typedef logic [PermWords-1:0][63:0] perm_t;

  localparam int unsigned SigmaMap [RateWords] = '{3, 0, 5, 1, 4, 2};

  function automatic logic [63:0] round_const(input logic [4:0] idx);
    logic [63:0] c;
    unique case (idx)
      5'd0:  c = 64'h243f6a8885a308d3;
      5'd1:  c = 64'h13198a2e03707344;
      5'd2:  c = 64'ha4093822299f31d0;
      5'd3:  c = 64'h082efa98ec4e6c89;
      5'd4:  c = 64'h452821e638d01377;
      5'd5:  c = 64'hbe5466cf34e90c6c;
      5'd6:  c = 64'hc0ac29b7c97c50dd;
      5'd7:  c = 64'h3f84d5b5b5470917;
      5'd8:  c = 64'h9216d5d98979fb1b;
      5'd9:  c = 64'hd1310ba698dfb5ac;
      5'd10: c = 64'h2ffd72dbd01adfb7;
      5'd11: c = 64'hb8e1afed6a267e96;
      5'd12: c = 64'hba7c9045f12c7f99;
      5'd13: c = 64'h24a19947b3916cf7;
      5'd14: c = 64'h0801f2e2858efc16;
      5'd15: c = 64'h636920d871574e69;
      5'd16: c = 64'ha458fea3f4933d7e;
      5'd17: c = 64'h0d95748f728eb658;
      5'd18: c = 64'h718bcd5882154aee;
      5'd19: c = 64'h7b54a41dc25a59b5;
      5'd20: c = 64'h9c30d5392af26013;
      5'd21: c = 64'hc5d1b023286085f0;
      5'd22: c = 64'hca417918b8db38ef;
      5'd23: c = 64'h8e79dcb0603a180e;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Cut the block at nbits (below 384) and set the 10* pad bit there.
  function automatic rate_t pad_block(input rate_t m, input logic [8:0] nbits);
    rate_t       r;
    logic [2:0]  w;
    logic [5:0]  b;
    logic [63:0] keep;
    w    = nbits[8:6];
    b    = nbits[5:0];
    keep = (b == 6'd0) ? 64'd0 : ~(64'hffffffffffffffff >> b);
    for (int i = 0; i < RateWords; i++) begin
      if (3'(i) < w) begin
        r[i] = m[i];
      end else if (3'(i) == w) begin
        r[i] = (m[i] & keep) | (TopBit >> b);
      end else begin
        r[i] = '0;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/dlsh_round.sv @@
// One round of the 960-bit permutation: S-box, linear mix, round constant,
// diffusion. Combinational; depends on dlsh_pkg.
module dlsh_round (
  input  dlsh_pkg::perm_t     state_i,
  input  logic [63:0]         rc_i,
  output dlsh_pkg::perm_t     state_o
);
  import dlsh_pkg::*;

  localparam int unsigned MixOff [7] = '{0, 3, 4, 5, 7, 8, 13};

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
    int unsigned s;
    s = n % 64;
    if (s == 0) return x;
    return (x << s) | (x >> (64 - s));
  endfunction

  logic [4:0][2:0][63:0] x;
  logic [4:0][2:0][63:0] y;

  // Bitsliced S-box, one column of five rows at a time.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [63:0] x0, x1, x2, x3, x4;
      logic [63:0] a34, a24, a23, a14, a12, a01, a13, a02, a04, a03;
      x0 = state_i[c*5+0]; x1 = state_i[c*5+1]; x2 = state_i[c*5+2];
      x3 = state_i[c*5+3]; x4 = state_i[c*5+4];
      a34 = x3 & x4; a24 = x2 & x4; a23 = x2 & x3; a14 = x1 & x4;
      a12 = x1 & x2; a01 = x0 & x1; a13 = x1 & x3; a02 = x0 & x2;
      a04 = x0 & x4; a03 = x0 & x3;
      x[0][c] = ~((x0 ^ a34) ^ (a24 ^ a23) ^ (a14 ^ a12) ^ (a01 ^ x4 ^ x2));
      x[1][c] = ~((x3 ^ x2) ^ (x0 ^ a24) ^ (a23 ^ a13) ^ (a12 ^ a02));
      x[2][c] = (a14 ^ a13) ^ (a12 ^ a04) ^ (a02 ^ a01) ^ (x2 ^ x0) ^ (a34 ^ a24);
      x[3][c] = ~((x4 ^ x3) ^ (x1 ^ x0) ^ (a12 ^ a03) ^ (a02 ^ a01));
      x[4][c] = (x1 ^ x0) ^ (a14 ^ a13) ^ (a12 ^ a04) ^ (a01 ^ x4 ^ x2);
    end
  end

  // Mix: each output word folds seven fixed source words; the constant goes into y[0][0] only.
  always_comb begin
    y = '0;
    for (int r = 0; r < 5; r++) begin
      for (int t = 0; t < 7; t++) begin
        for (int c = 0; c < 3; c++) begin
          y[r][c] ^= x[(r + MixOff[t]) % 5][(c + ((r + MixOff[t]) / 5) % 3) % 3];
        end
      end
    end
    y[0][0] ^= rc_i;
  end

  always_comb begin
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 3; c++) begin
        state_o[c*5+r] = rotl(y[r][c], r + 5*c) ^ rotl(y[r][c], r + 5*c + Rot1)
                       ^ rotl(y[r][c], r + 5*c + Rot2);
      end
    end
  end

endmodule

@@ rtl/dual_lane_sponge_hash.sv @@
// Dual-lane sponge hash top: lane and capacity state, round sequencer, squeeze
// and output register. Depends on dlsh_pkg and dlsh_round.
//
//   channel | signals                          | dir | word
//   in      | in_valid_i/in_ready_o/in_data_i  | in  | one 384-bit block
//   out     | out_valid_o/out_ready_i/out_data_o| out | one 64-bit digest word
//   cfg     | cfg_valid_i/cfg_ready_o/cfg_data_i| in  | digest length in bits
//
// One round unit is shared by every permutation, one round per cycle. A block
// takes two 12-round permutations; a last block of 384 valid bits adds two
// for a padding-only block. Squeeze gives one word per cycle unless stalled,
// with an empty permutation after every ninth word. in_ready_o is low from
// accept until the block is absorbed, or the final digest word taken. Reset
// clears state and sets digest length to 512; output stalls hold the squeeze.
module dual_lane_sponge_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dlsh_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dlsh_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [12:0]         cfg_data_i
);
  import dlsh_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PERM = 2'd1;
  localparam logic [1:0] ST_SQZ  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [1:0] PH_ABS_A = 2'd0;
  localparam logic [1:0] PH_ABS_B = 2'd1;
  localparam logic [1:0] PH_SQZ_A = 2'd2;
  localparam logic [1:0] PH_SQZ_B = 2'd3;

  logic [1:0]  st_q, st_d, ph_q, ph_d;
  logic [3:0]  rnd_q, rnd_d, j_q, j_d;
  logic [6:0]  k_q, k_d, nwords_q, nwords_d;
  logic [5:0]  tail_q, tail_d;
  logic [12:0] dbits_q;
  logic        pad_q, pad_d, last_q, last_d, sel_a_q, sel_a_d, ov_q, ov_d;
  rate_t       lane_a_q, lane_a_d, lane_b_q, lane_b_d, msg_q, msg_d;
  cap_t        cap_q, cap_d;
  perm_t       p_q, p_d, rout;
  out_item_t   out_q, out_d;

  rate_t       in_blk, sig_msg, pad_only;
  cap_t        cap_new;
  logic [12:0] nbits;
  logic [4:0]  rc_idx;
  logic [63:0] sq_word;
  logic [13:0] nb_up;

  dlsh_round u_round (
    .state_i (p_q),
    .rc_i    (round_const(rc_idx)),
    .state_o (rout)
  );

  assign rc_idx = ((ph_q == PH_ABS_B) || (ph_q == PH_SQZ_B))
                  ? 5'(LaneBRcOffset) + {1'b0, rnd_q} : {1'b0, rnd_q};

  assign in_blk = {in_data_i.word5, in_data_i.word4, in_data_i.word3,
                   in_data_i.word2, in_data_i.word1, in_data_i.word0};

  always_comb begin
    pad_only    = '0;
    pad_only[0] = TopBit;
    for (int i = 0; i < RateWords; i++) begin
      sig_msg[i] = msg_q[SigmaMap[i]];
    end
    for (int i = 0; i < CapWords; i++) begin
      cap_new[i] = cap_q[i] ^ rout[RateWords+i];
    end
  end

  // Clamp the digest length to 1..DigestMaxBits.
  always_comb begin
    if (dbits_q == 13'd0) begin
      nbits = 13'd1;
    end else if (dbits_q > 13'(DigestMaxBits)) begin
      nbits = 13'(DigestMaxBits);
    end else begin
      nbits = dbits_q;
    end
    nb_up = {1'b0, nbits} + 14'd63;
  end

  always_comb begin
    sq_word = cap_q[j_q];
    if ((k_q + 7'd1 == nwords_q) && (tail_q != 6'd0)) begin
      sq_word = sq_word & ~(64'hffffffffffffffff >> tail_q);
    end
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_comb begin
    st_d     = st_q;
    ph_d     = ph_q;
    rnd_d    = rnd_q;
    j_d      = j_q;
    k_d      = k_q;
    nwords_d = nwords_q;
    tail_d   = tail_q;
    pad_d    = pad_q;
    last_d   = last_q;
    sel_a_d  = sel_a_q;
    lane_a_d = lane_a_q;
    lane_b_d = lane_b_q;
    cap_d    = cap_q;
    msg_d    = msg_q;
    p_d      = p_q;
    out_d    = out_q;
    ov_d     = ov_q && !out_ready_i;

    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.last_block && (in_data_i.valid_bits < 9'd384)) begin
            msg_d = pad_block(in_blk, in_data_i.valid_bits);
          end else begin
            msg_d = in_blk;
          end
          pad_d    = in_data_i.last_block && (in_data_i.valid_bits >= 9'd384);
          last_d   = in_data_i.last_block;
          nwords_d = nb_up[12:6];
          tail_d   = nbits[5:0];
          for (int i = 0; i < RateWords; i++) p_d[i] = lane_a_q[i] ^ msg_d[i];
          for (int i = 0; i < CapWords; i++) p_d[RateWords+i] = cap_q[i];
          ph_d  = PH_ABS_A;
          rnd_d = '0;
          st_d  = ST_PERM;
        end
      end
      ST_PERM: begin
        p_d   = rout;
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == 4'(RoundCount - 1)) begin
          cap_d = cap_new;
          rnd_d = '0;
          unique case (ph_q)
            PH_ABS_A: begin
              lane_a_d = rout[RateWords-1:0];
              ph_d     = PH_ABS_B;
              for (int i = 0; i < RateWords; i++) p_d[i] = lane_b_q[i] ^ sig_msg[i];
              for (int i = 0; i < CapWords; i++) p_d[RateWords+i] = cap_new[i];
            end
            PH_ABS_B: begin
              lane_b_d = rout[RateWords-1:0];
              if (pad_q) begin
                // absorb the padding-only block next
                msg_d = pad_only;
                pad_d = 1'b0;
                ph_d  = PH_ABS_A;
                for (int i = 0; i < RateWords; i++) p_d[i] = lane_a_q[i] ^ pad_only[i];
                for (int i = 0; i < CapWords; i++) p_d[RateWords+i] = cap_new[i];
              end else if (last_q) begin
                st_d    = ST_SQZ;
                k_d     = '0;
                j_d     = '0;
                sel_a_d = 1'b1;
              end else begin
                st_d = ST_IDLE;
              end
            end
            PH_SQZ_A: begin
              lane_a_d = rout[RateWords-1:0];
              st_d     = ST_SQZ;
            end
            PH_SQZ_B: begin
              lane_b_d = rout[RateWords-1:0];
              st_d     = ST_SQZ;
            end
            default: ;
          endcase
        end
      end
      ST_SQZ: begin
        if (!ov_q || out_ready_i) begin
          ov_d              = 1'b1;
          out_d.digest_word = sq_word;
          out_d.last_word   = (k_q + 7'd1 == nwords_q);
          if (k_q + 7'd1 == nwords_q) begin
            st_d = ST_DONE;
          end else begin
            k_d = k_q + 7'd1;
            if (j_q == 4'(CapWords - 1)) begin
              // nine words drained: run an empty permutation on the next lane
              j_d     = '0;
              sel_a_d = !sel_a_q;
              ph_d    = sel_a_q ? PH_SQZ_A : PH_SQZ_B;
              rnd_d   = '0;
              st_d    = ST_PERM;
              for (int i = 0; i < RateWords; i++) begin
                p_d[i] = sel_a_q ? lane_a_q[i] : lane_b_q[i];
              end
              for (int i = 0; i < CapWords; i++) p_d[RateWords+i] = cap_q[i];
            end else begin
              j_d = j_q + 4'd1;
            end
          end
        end
      end
      ST_DONE: begin
        if (ov_q && out_ready_i) begin
          lane_a_d = '0;
          lane_b_d = '0;
          cap_d    = '0;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ph_q     <= PH_ABS_A;
      rnd_q    <= '0;
      j_q      <= '0;
      k_q      <= '0;
      nwords_q <= '0;
      tail_q   <= '0;
      pad_q    <= 1'b0;
      last_q   <= 1'b0;
      sel_a_q  <= 1'b1;
      ov_q     <= 1'b0;
      dbits_q  <= 13'd512;
      lane_a_q <= '0;
      lane_b_q <= '0;
      cap_q    <= '0;
    end else begin
      st_q     <= st_d;
      ph_q     <= ph_d;
      rnd_q    <= rnd_d;
      j_q      <= j_d;
      k_q      <= k_d;
      nwords_q <= nwords_d;
      tail_q   <= tail_d;
      pad_q    <= pad_d;
      last_q   <= last_d;
      sel_a_q  <= sel_a_d;
      ov_q     <= ov_d;
      lane_a_q <= lane_a_d;
      lane_b_q <= lane_b_d;
      cap_q    <= cap_d;
      if (cfg_valid_i) begin
        dbits_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q <= msg_d;
    p_q   <= p_d;
    out_q <= out_d;
  end

endmodule
